// File: rtl/lcf_pkg.sv
package lcf_pkg;

  localparam int unsigned DATA_W = 16;
  localparam int unsigned CMD_W = 3;
  localparam int unsigned ROW_W = 7;
  localparam int unsigned COL_W = 6;
  localparam int unsigned LANE_W = 2;
  localparam int unsigned UNIT_W = 5;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned GATES = 4;

  localparam logic [CMD_W-1:0] CMD_W_IH = 3'd0;
  localparam logic [CMD_W-1:0] CMD_W_HH = 3'd1;
  localparam logic [CMD_W-1:0] CMD_B_IH = 3'd2;
  localparam logic [CMD_W-1:0] CMD_B_HH = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FEED = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_INPUT_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIDDEN_SIZE = 1'd1;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [ROW_W-1:0] row_index;
    logic [COL_W-1:0] column_index;
    logic [LANE_W-1:0] lane;
    logic sequence_start;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [UNIT_W-1:0] unit_index;
    logic [LANE_W-1:0] result_lane;
    logic signed [DATA_W-1:0] hidden_value;
    logic last_unit;
  } out_item_t;

  function automatic logic [12:0] sig_knot(input logic [4:0] n);
    logic [12:0] r;
    unique case (n)
      5'd0: r = 13'd2048; 5'd1: r = 13'd2550; 5'd2: r = 13'd2994;
      5'd3: r = 13'd3349; 5'd4: r = 13'd3608; 5'd5: r = 13'd3785;
      5'd6: r = 13'd3902; 5'd7: r = 13'd3976; 5'd8: r = 13'd4022;
      5'd9: r = 13'd4051; 5'd10: r = 13'd4069; 5'd11: r = 13'd4079;
      5'd12: r = 13'd4086; 5'd13: r = 13'd4090; 5'd14: r = 13'd4092;
      5'd15: r = 13'd4094;
      default: r = 13'd4095;
    endcase
    return r;
  endfunction

  function automatic logic [12:0] tanh_knot(input logic [4:0] n);
    logic [12:0] r;
    unique case (n)
      5'd0: r = 13'd0; 5'd1: r = 13'd1893; 5'd2: r = 13'd3119;
      5'd3: r = 13'd3707; 5'd4: r = 13'd3949; 5'd5: r = 13'd4041;
      5'd6: r = 13'd4076; 5'd7: r = 13'd4089; 5'd8: r = 13'd4093;
      5'd9: r = 13'd4095;
      default: r = 13'd4096;
    endcase
    return r;
  endfunction

  // piecewise linear activation; is_tanh selects the table
  function automatic logic signed [13:0] act_f(input logic signed [DATA_W-1:0] x,
                                                input logic is_tanh);
    logic [16:0] a;
    logic [5:0] n;
    logic [10:0] fr;
    logic signed [13:0] t0, t1;
    logic signed [27:0] p;
    logic signed [13:0] v;
    logic signed [13:0] r;
    a = x[DATA_W-1] ? 17'(-$signed({x[DATA_W-1], x})) : 17'({1'b0, x});
    n = a[16:11];
    fr = a[10:0];
    t0 = is_tanh ? 14'(tanh_knot(n[4:0])) : 14'(sig_knot(n[4:0]));
    t1 = is_tanh ? 14'(tanh_knot(n[4:0] + 5'd1)) : 14'(sig_knot(n[4:0] + 5'd1));
    p = 28'((t1 - t0) * $signed({1'b0, fr})) + 28'sd1024;
    if (n >= 6'd16) begin
      v = is_tanh ? 14'(tanh_knot(5'd16)) : 14'(sig_knot(5'd16));
    end else begin
      v = t0 + 14'(p >>> 11);
    end
    if (!x[DATA_W-1]) begin
      r = v;
    end else if (is_tanh) begin
      r = -v;
    end else begin
      r = 14'sd4096 - v;
    end
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [47:0] v);
    logic signed [47:0] w;
    logic signed [35:0] r;
    w = v + 48'sd2048;
    r = 36'(w >>> 12);
    if (r > 36'sd32767) begin
      return 16'sh7fff;
    end else if (r < -36'sd32768) begin
      return 16'sh8000;
    end
    return r[DATA_W-1:0];
  endfunction

endpackage

// File: rtl/lcf_stream_if.sv
interface lcf_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/lcf_ram.sv
module lcf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic clk_i,
  input  logic we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: rtl/lstm_cell_forward_top.sv
// lstm_cell_forward_top: four-gate lstm cell inference over q4.12 data
// in_s carries items: weight and bias loads (cmd 0..3) and feed items (cmd 4)
// a load or a non-triggering feed leaves the sequencer idle; a feed whose
// element index equals input_size_used-1 starts a time step for its lane
// a step runs one shared multiply-accumulate over the weight memories: per unit
// and gate it loads the biases, adds the input products, then the recurrent
// products (skipped on sequence_start) and rounds the sum; then the cell update
// forms the activations, the new c, tanh of c and the new h
// every memory read is registered; one product per cycle is the limit
// results leave on out_m, one item per hidden unit in ascending order, the
// last with last_unit set; a stalled receiver holds the sequencer at the
// output register and no item is taken until the step has drained
// new h and c are kept in a scratch slot and copied to the lane's state after
// the last unit, so the step reads only the previous time step's h
// reset clears the state memories' valid bits (h and c read as zero), the
// sizes go to 64 and 32; weight, bias and input memories are undefined until
// written
// cfg_we_i writes register cfg_idx_i (0 input size, 1 hidden size)
module lstm_cell_forward_top #(
  parameter int unsigned INPUT_MAX = 64,
  parameter int unsigned HIDDEN_MAX = 32,
  parameter int unsigned LANES = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [lcf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lcf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  lcf_stream_if.sink in_s,
  lcf_stream_if.source out_m
);
  localparam int unsigned ROWS = lcf_pkg::GATES * HIDDEN_MAX;
  localparam int unsigned IW = $clog2(INPUT_MAX) > 0 ? $clog2(INPUT_MAX) : 1;
  localparam int unsigned HW = $clog2(HIDDEN_MAX) > 0 ? $clog2(HIDDEN_MAX) : 1;
  localparam int unsigned RW = $clog2(ROWS);
  localparam int unsigned LW = $clog2(LANES) > 0 ? $clog2(LANES) : 1;
  localparam int unsigned SW = $clog2(LANES + 1);
  localparam int unsigned SD = (LANES + 1) * HIDDEN_MAX;
  localparam int unsigned SAW = $clog2(SD);
  localparam int unsigned WIH_D = ROWS * INPUT_MAX;
  localparam int unsigned WHH_D = ROWS * HIDDEN_MAX;
  localparam int unsigned WIA = $clog2(WIH_D);
  localparam int unsigned WHA = $clog2(WHH_D);
  localparam int unsigned DW = lcf_pkg::DATA_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_BIAS = 4'd1;
  localparam logic [3:0] S_MACX = 4'd2;
  localparam logic [3:0] S_MACH = 4'd3;
  localparam logic [3:0] S_DRAIN = 4'd4;
  localparam logic [3:0] S_ACT = 4'd5;
  localparam logic [3:0] S_CRD = 4'd6;
  localparam logic [3:0] S_CELL = 4'd7;
  localparam logic [3:0] S_H = 4'd8;
  localparam logic [3:0] S_OUT = 4'd9;
  localparam logic [3:0] S_COPY = 4'd10;
  localparam logic [3:0] S_COPYW = 4'd11;
  localparam logic [3:0] S_ACCW = 4'd12;
  localparam logic [3:0] S_TC = 4'd13;

  logic [6:0] in_size_q;
  logic [5:0] hid_size_q;
  logic [IW:0] n_in;
  logic [HW:0] n_h;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_size_q <= 7'd64;
      hid_size_q <= 6'd32;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lcf_pkg::REG_INPUT_SIZE: in_size_q <= cfg_data_i;
        lcf_pkg::REG_HIDDEN_SIZE: hid_size_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (in_size_q == 7'd0) begin
      n_in = (IW+1)'(1);
    end else if (32'(in_size_q) > INPUT_MAX) begin
      n_in = (IW+1)'(INPUT_MAX);
    end else begin
      n_in = (IW+1)'(in_size_q);
    end
    if (hid_size_q == 6'd0) begin
      n_h = (HW+1)'(1);
    end else if (32'(hid_size_q) > HIDDEN_MAX) begin
      n_h = (HW+1)'(HIDDEN_MAX);
    end else begin
      n_h = (HW+1)'(hid_size_q);
    end
  end

  lcf_pkg::in_item_t it;
  assign it = in_s.payload;

  logic [3:0] state_q, state_d;
  logic acc_in;
  assign in_s.ready = (state_q == S_IDLE);
  assign acc_in = in_s.valid && in_s.ready;

  logic ld_row_ok, ld_wih, ld_whh, ld_bih, ld_bhh, feed_ok, trig;
  assign ld_row_ok = 32'(it.row_index) < ROWS;
  assign ld_wih = acc_in && it.cmd == lcf_pkg::CMD_W_IH && ld_row_ok
                  && 32'(it.column_index) < INPUT_MAX;
  assign ld_whh = acc_in && it.cmd == lcf_pkg::CMD_W_HH && ld_row_ok
                  && 32'(it.column_index) < HIDDEN_MAX;
  assign ld_bih = acc_in && it.cmd == lcf_pkg::CMD_B_IH && ld_row_ok;
  assign ld_bhh = acc_in && it.cmd == lcf_pkg::CMD_B_HH && ld_row_ok;
  assign feed_ok = acc_in && it.cmd == lcf_pkg::CMD_FEED
                   && (IW+1)'(it.column_index) < n_in && 32'(it.lane) < LANES;
  assign trig = feed_ok && (IW+1)'(it.column_index) == n_in - (IW+1)'(1);

  // step counters
  logic [LW-1:0] lane_q;
  logic start_q;
  logic [HW-1:0] k_q, k_d;
  logic [1:0] g_q, g_d;
  logic [IW:0] j_q, j_d;
  logic [RW-1:0] row;
  assign row = RW'(32'(g_q) * 32'(n_h) + 32'(k_q));

  // memories
  logic [DW-1:0] wih_rd, whh_rd, bih_rd, bhh_rd, x_rd, h_rd, c_rd;
  logic [WIA-1:0] wih_ra;
  logic [WHA-1:0] whh_ra;
  logic [IW-1:0] x_ra;
  logic [SAW-1:0] h_ra, c_ra, st_wa;
  logic st_we;
  logic [DW-1:0] h_wd, c_wd;

  assign wih_ra = WIA'(32'(row) * INPUT_MAX + 32'(j_q));
  assign whh_ra = WHA'(32'(row) * HIDDEN_MAX + 32'(j_q));
  assign x_ra = IW'(j_q);

  lcf_ram #(.WIDTH(DW), .DEPTH(WIH_D)) u_wih (
    .clk_i, .we_i(ld_wih),
    .waddr_i(WIA'(32'(it.row_index) * INPUT_MAX + 32'(it.column_index))),
    .wdata_i(it.value), .raddr_i(wih_ra), .rdata_o(wih_rd));
  lcf_ram #(.WIDTH(DW), .DEPTH(WHH_D)) u_whh (
    .clk_i, .we_i(ld_whh),
    .waddr_i(WHA'(32'(it.row_index) * HIDDEN_MAX + 32'(it.column_index))),
    .wdata_i(it.value), .raddr_i(whh_ra), .rdata_o(whh_rd));
  lcf_ram #(.WIDTH(DW), .DEPTH(ROWS)) u_bih (
    .clk_i, .we_i(ld_bih), .waddr_i(RW'(it.row_index)), .wdata_i(it.value),
    .raddr_i(row), .rdata_o(bih_rd));
  lcf_ram #(.WIDTH(DW), .DEPTH(ROWS)) u_bhh (
    .clk_i, .we_i(ld_bhh), .waddr_i(RW'(it.row_index)), .wdata_i(it.value),
    .raddr_i(row), .rdata_o(bhh_rd));
  lcf_ram #(.WIDTH(DW), .DEPTH(INPUT_MAX)) u_x (
    .clk_i, .we_i(feed_ok), .waddr_i(IW'(it.column_index)), .wdata_i(it.value),
    .raddr_i(x_ra), .rdata_o(x_rd));
  lcf_ram #(.WIDTH(DW), .DEPTH(SD)) u_h (
    .clk_i, .we_i(st_we), .waddr_i(st_wa), .wdata_i(h_wd),
    .raddr_i(h_ra), .rdata_o(h_rd));
  lcf_ram #(.WIDTH(DW), .DEPTH(SD)) u_c (
    .clk_i, .we_i(st_we), .waddr_i(st_wa), .wdata_i(c_wd),
    .raddr_i(c_ra), .rdata_o(c_rd));

  // valid bits for the state memories (slot LANES is scratch)
  logic [SD-1:0] sv_q;
  logic h_ok_q, c_ok_q;

  // datapath registers
  logic mac_q, mac_x_q;
  logic signed [47:0] acc_q;
  logic signed [DW-1:0] pre_q [lcf_pkg::GATES];
  logic signed [13:0] a_i_q, a_f_q, a_g_q, a_o_q;
  logic signed [DW-1:0] c_new_q, h_new_q;
  logic signed [13:0] tc_q;
  logic signed [DW-1:0] cprev;
  lcf_pkg::out_item_t out_q;
  logic out_v_q;

  assign cprev = (start_q || !c_ok_q) ? '0 : $signed(c_rd);

  always_comb begin
    h_ra = SAW'(32'(lane_q) * HIDDEN_MAX + 32'(j_q));
    c_ra = SAW'(32'(lane_q) * HIDDEN_MAX + 32'(k_q));
    if (state_q == S_COPY) begin
      h_ra = SAW'(LANES * HIDDEN_MAX + 32'(k_q));
      c_ra = h_ra;
    end
  end

  always_comb begin
    st_we = 1'b0;
    st_wa = SAW'(LANES * HIDDEN_MAX + 32'(k_q));
    h_wd = h_new_q;
    c_wd = c_new_q;
    if (state_q == S_OUT && !out_v_q) begin
      st_we = 1'b1;
    end else if (state_q == S_COPYW) begin
      st_we = 1'b1;
      st_wa = SAW'(32'(lane_q) * HIDDEN_MAX + 32'(k_q));
      h_wd = h_rd;
      c_wd = c_rd;
    end
  end

  logic last_g, last_k;
  assign last_g = g_q == 2'd3;
  assign last_k = (HW+1)'(k_q) == n_h - (HW+1)'(1);

  always_comb begin
    state_d = state_q;
    k_d = k_q;
    g_d = g_q;
    j_d = j_q;
    unique case (state_q)
      S_IDLE: if (trig) begin
        state_d = S_BIAS;
        k_d = '0;
        g_d = '0;
        j_d = '0;
      end
      S_BIAS: state_d = S_MACX;
      S_MACX: begin
        if (j_q == n_in - (IW+1)'(1)) begin
          j_d = '0;
          state_d = start_q ? S_ACCW : S_MACH;
        end else begin
          j_d = j_q + (IW+1)'(1);
        end
      end
      S_MACH: begin
        if (j_q == (IW+1)'(n_h) - (IW+1)'(1)) begin
          j_d = '0;
          state_d = S_ACCW;
        end else begin
          j_d = j_q + (IW+1)'(1);
        end
      end
      // last product lands in the accumulator
      S_ACCW: state_d = S_DRAIN;
      S_DRAIN: begin
        if (last_g) begin
          state_d = S_ACT;
          g_d = '0;
        end else begin
          g_d = g_q + 2'd1;
          state_d = S_BIAS;
        end
      end
      S_ACT: state_d = S_CRD;
      S_CRD: state_d = S_CELL;
      S_CELL: state_d = S_TC;
      S_TC: state_d = S_H;
      S_H: state_d = S_OUT;
      S_OUT: if (!out_v_q) begin
        if (last_k) begin
          state_d = S_COPY;
          k_d = '0;
        end else begin
          k_d = k_q + HW'(1);
          state_d = S_BIAS;
        end
      end
      S_COPY: state_d = S_COPYW;
      S_COPYW: begin
        if (last_k) begin
          state_d = S_IDLE;
        end else begin
          k_d = k_q + HW'(1);
          state_d = S_COPY;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q <= '0;
      g_q <= '0;
      j_q <= '0;
      sv_q <= '0;
      out_v_q <= 1'b0;
      mac_q <= 1'b0;
      lane_q <= '0;
      start_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q <= k_d;
      g_q <= g_d;
      j_q <= j_d;
      mac_q <= state_q == S_MACX || state_q == S_MACH;
      if (trig) begin
        lane_q <= LW'(it.lane);
        start_q <= it.sequence_start;
      end
      if (st_we) begin
        sv_q[st_wa] <= 1'b1;
      end
      if (state_q == S_OUT && !out_v_q) begin
        out_v_q <= 1'b1;
      end else if (out_m.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mac_x_q <= state_q == S_MACX;
    h_ok_q <= sv_q[h_ra];
    c_ok_q <= sv_q[c_ra];
    if (state_q == S_MACX && j_q == '0) begin
      acc_q <= 48'($signed(bih_rd) + $signed(bhh_rd)) <<< 12;
    end else if (mac_q) begin
      if (mac_x_q) begin
        acc_q <= acc_q + 48'($signed(wih_rd) * $signed(x_rd));
      end else begin
        acc_q <= acc_q + 48'($signed(whh_rd) * $signed(h_ok_q ? h_rd : '0));
      end
    end
    if (state_q == S_DRAIN) begin
      pre_q[g_q] <= lcf_pkg::round_sat(acc_q);
    end
    if (state_q == S_ACT) begin
      a_i_q <= lcf_pkg::act_f(pre_q[0], 1'b0);
      a_f_q <= lcf_pkg::act_f(pre_q[1], 1'b0);
      a_g_q <= lcf_pkg::act_f(pre_q[2], 1'b1);
      a_o_q <= lcf_pkg::act_f(pre_q[3], 1'b0);
    end
    if (state_q == S_CELL) begin
      c_new_q <= lcf_pkg::round_sat(48'(a_f_q * cprev) + 48'(a_i_q * a_g_q));
    end
    if (state_q == S_TC) begin
      tc_q <= lcf_pkg::act_f(c_new_q, 1'b1);
    end
    if (state_q == S_H) begin
      h_new_q <= lcf_pkg::round_sat(48'(a_o_q * tc_q));
    end
    if (state_q == S_OUT && !out_v_q) begin
      out_q.unit_index <= lcf_pkg::UNIT_W'(k_q);
      out_q.result_lane <= lcf_pkg::LANE_W'(lane_q);
      out_q.hidden_value <= h_new_q;
      out_q.last_unit <= last_k;
    end
  end

  assign out_m.valid = out_v_q;
  assign out_m.payload = out_q;

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int IN_MAX = 64;
  localparam int HID_MAX = 32;
  localparam int NLANES = 4;
  localparam int NROWS = lcf_pkg::GATES * HID_MAX;
  // largest sizes that the stimulus selects; stores are filled for these
  localparam int USE_IN = 8;
  localparam int USE_HID = 4;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [lcf_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [lcf_pkg::CFG_DATA_W-1:0] cfg_data_i;

  lcf_stream_if #(.T(lcf_pkg::in_item_t)) in_if ();
  lcf_stream_if #(.T(lcf_pkg::out_item_t)) out_if ();

  lstm_cell_forward_top dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_s(in_if),
    .out_m(out_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // lstm predictor state
  shortint w_in [NROWS*IN_MAX];
  shortint w_rec [NROWS*HID_MAX];
  shortint b_in [NROWS];
  shortint b_rec [NROWS];
  shortint x_buf [IN_MAX];
  shortint h_st [NLANES*HID_MAX];
  shortint c_st [NLANES*HID_MAX];
  logic [6:0] in_size_reg;
  logic [5:0] hid_size_reg;

  int sig_tab [17] = '{2048, 2550, 2994, 3349, 3608, 3785, 3902, 3976, 4022,
                       4051, 4069, 4079, 4086, 4090, 4092, 4094, 4095};
  int tanh_tab [17] = '{0, 1893, 3119, 3707, 3949, 4041, 4076, 4089, 4093,
                        4095, 4096, 4096, 4096, 4096, 4096, 4096, 4096};

  lcf_pkg::in_item_t pending [$];
  lcf_pkg::out_item_t expected_h [$];
  int errors = 0;
  bit no_idle = 1'b1;
  int hold_tok = 0;

  function automatic int fix_round(longint v);
    longint r;
    r = (v + 2048) >>> 12;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return int'(r);
  endfunction

  function automatic int pwl(bit use_tanh, int a);
    int n;
    int frac;
    int t0;
    int t1;
    n = a >> 11;
    frac = a & 2047;
    if (n >= 16) return use_tanh ? tanh_tab[16] : sig_tab[16];
    t0 = use_tanh ? tanh_tab[n] : sig_tab[n];
    t1 = use_tanh ? tanh_tab[n+1] : sig_tab[n+1];
    return t0 + (((t1 - t0) * frac + 1024) >>> 11);
  endfunction

  function automatic int sigm(int x);
    if (x < 0) return 4096 - pwl(1'b0, -x);
    return pwl(1'b0, x);
  endfunction

  function automatic int tanh_f(int x);
    if (x < 0) return -pwl(1'b1, -x);
    return pwl(1'b1, x);
  endfunction

  function automatic int eff_in();
    if (in_size_reg < 1) return 1;
    if (in_size_reg > IN_MAX) return IN_MAX;
    return in_size_reg;
  endfunction

  function automatic int eff_hid();
    if (hid_size_reg < 1) return 1;
    if (hid_size_reg > HID_MAX) return HID_MAX;
    return hid_size_reg;
  endfunction

  task automatic predict_item(lcf_pkg::in_item_t it);
    int ni;
    int nh;
    int r;
    int c_prev;
    int lb;
    longint acc;
    int act [lcf_pkg::GATES];
    shortint nh_v [HID_MAX];
    shortint nc_v [HID_MAX];
    lcf_pkg::out_item_t o;
    ni = eff_in();
    nh = eff_hid();
    lb = int'(it.lane) * HID_MAX;
    case (it.cmd)
      lcf_pkg::CMD_W_IH: w_in[it.row_index*IN_MAX + it.column_index] = it.value;
      lcf_pkg::CMD_W_HH: if (it.column_index < HID_MAX)
        w_rec[it.row_index*HID_MAX + it.column_index] = it.value;
      lcf_pkg::CMD_B_IH: b_in[it.row_index] = it.value;
      lcf_pkg::CMD_B_HH: b_rec[it.row_index] = it.value;
      lcf_pkg::CMD_FEED: if (it.column_index < ni) begin
        x_buf[it.column_index] = it.value;
        if (it.column_index == ni - 1) begin
          for (int k = 0; k < nh; k++) begin
            for (int g = 0; g < lcf_pkg::GATES; g++) begin
              r = g * nh + k;
              acc = (longint'(b_in[r]) + longint'(b_rec[r])) * 4096;
              for (int j = 0; j < ni; j++)
                acc += longint'(w_in[r*IN_MAX + j]) * longint'(x_buf[j]);
              if (!it.sequence_start)
                for (int j = 0; j < nh; j++)
                  acc += longint'(w_rec[r*HID_MAX + j]) * longint'(h_st[lb + j]);
              act[g] = fix_round(acc);
            end
            act[0] = sigm(act[0]);
            act[1] = sigm(act[1]);
            act[2] = tanh_f(act[2]);
            act[3] = sigm(act[3]);
            c_prev = it.sequence_start ? 0 : c_st[lb + k];
            nc_v[k] = shortint'(fix_round(longint'(act[1]) * c_prev +
                                          longint'(act[0]) * act[2]));
            nh_v[k] = shortint'(fix_round(longint'(act[3]) * tanh_f(nc_v[k])));
          end
          for (int k = 0; k < nh; k++) begin
            h_st[lb + k] = nh_v[k];
            c_st[lb + k] = nc_v[k];
            o.unit_index = lcf_pkg::UNIT_W'(k);
            o.result_lane = it.lane;
            o.hidden_value = nh_v[k];
            o.last_unit = (k == nh - 1);
            expected_h.push_back(o);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_hidden(lcf_pkg::out_item_t got);
    lcf_pkg::out_item_t e;
    if (expected_h.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected item: %p", got);
      return;
    end
    e = expected_h.pop_front();
    if (got.unit_index !== e.unit_index || got.result_lane !== e.result_lane ||
        got.hidden_value !== e.hidden_value || got.last_unit !== e.last_unit) begin
      errors++;
      if (errors <= 10) $display("mismatch: expected %p got %p", e, got);
    end
  endtask

  function automatic int pick_gap();
    if (no_idle) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // driver
  int tx_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.payload <= '0;
      tx_gap <= 0;
    end else begin
      if (in_if.valid && in_if.ready) predict_item(in_if.payload);
      if (!in_if.valid || in_if.ready) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          in_if.valid <= 1'b0;
        end else if (pending.size() > 0) begin
          in_if.payload <= pending.pop_front();
          in_if.valid <= 1'b1;
          tx_gap <= pick_gap();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int rx_gap;
  int hold_left;
  int seen_tok;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      rx_gap <= 0;
      hold_left <= 0;
      seen_tok <= 0;
    end else begin
      if (out_if.valid && out_if.ready) check_hidden(out_if.payload);
      if (hold_tok != seen_tok) begin
        seen_tok <= hold_tok;
        hold_left <= 2000;
        out_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_if.ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        rx_gap <= pick_gap();
      end
    end
  end

  function automatic lcf_pkg::in_item_t mk(logic [lcf_pkg::CMD_W-1:0] cmd, int row, int col,
                                           int lane, bit st, shortint val);
    lcf_pkg::in_item_t it;
    it.cmd = cmd;
    it.row_index = lcf_pkg::ROW_W'(row);
    it.column_index = lcf_pkg::COL_W'(col);
    it.lane = lcf_pkg::LANE_W'(lane);
    it.sequence_start = st;
    it.value = val;
    return it;
  endfunction

  function automatic shortint rand_val();
    if ($urandom_range(0, 7) == 0) return shortint'($urandom_range(0, 65535));
    return shortint'(int'($urandom_range(0, 2047)) - 1024);
  endfunction

  function automatic bit rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  task automatic wait_idle();
    while (pending.size() != 0 || in_if.valid || expected_h.size() != 0)
      @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [lcf_pkg::CFG_IDX_W-1:0] idx,
                           logic [lcf_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    if (idx == lcf_pkg::REG_INPUT_SIZE) in_size_reg = data;
    else hid_size_reg = data[5:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic push_sequence(int n, bit full_rand);
    int ln;
    ln = $urandom_range(0, NLANES - 1);
    for (int j = 0; j < n; j++)
      pending.push_back(mk(lcf_pkg::CMD_FEED, $urandom_range(0, 127), j, full_rand ?
                           $urandom_range(0, 3) : ln, rand_bit(), rand_val()));
  endtask

  int in_cfg [9] = '{1, 0, 5, 8, 2, 7, 6, 4, 3};
  int hid_cfg [9] = '{1, 0, 4, 3, 2, 4, 1, 4, 2};
  int quota;
  int cnt;
  int ni;

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_size_reg = 7'd64;
    hid_size_reg = 6'd32;
    foreach (h_st[i]) h_st[i] = 0;
    foreach (c_st[i]) c_st[i] = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // fill every store entry that the chosen sizes read
    write_reg(lcf_pkg::REG_INPUT_SIZE, lcf_pkg::CFG_DATA_W'(USE_IN));
    write_reg(lcf_pkg::REG_HIDDEN_SIZE, lcf_pkg::CFG_DATA_W'(USE_HID));
    for (int r = 0; r < lcf_pkg::GATES * USE_HID; r++) begin
      for (int c = 0; c < USE_IN; c++)
        pending.push_back(mk(lcf_pkg::CMD_W_IH, r, c, 0, 1'b0, rand_val()));
      for (int c = 0; c < USE_HID; c++)
        pending.push_back(mk(lcf_pkg::CMD_W_HH, r, c, 0, 1'b0, rand_val()));
      pending.push_back(mk(lcf_pkg::CMD_B_IH, r, 0, 0, 1'b0, rand_val()));
      pending.push_back(mk(lcf_pkg::CMD_B_HH, r, 0, 0, 1'b0, rand_val()));
    end
    for (int j = 0; j < USE_IN; j++)
      pending.push_back(mk(lcf_pkg::CMD_FEED, 0, j, 0, 1'b1, rand_val()));
    wait_idle();

    // directed
    write_reg(lcf_pkg::REG_INPUT_SIZE, 7'd3);
    write_reg(lcf_pkg::REG_HIDDEN_SIZE, 7'd2);
    pending.push_back(mk(lcf_pkg::CMD_FEED, 0, 0, 0, 1'b0, 16'sh7fff));
    pending.push_back(mk(lcf_pkg::CMD_FEED, 0, 1, 0, 1'b0, 16'sh7fff));
    pending.push_back(mk(lcf_pkg::CMD_FEED, 0, 2, 0, 1'b1, 16'sh7fff));
    pending.push_back(mk(lcf_pkg::CMD_FEED, 0, 0, 3, 1'b0, -16'sh8000));
    pending.push_back(mk(lcf_pkg::CMD_FEED, 0, 1, 3, 1'b1, -16'sh8000));
    pending.push_back(mk(lcf_pkg::CMD_FEED, 0, 2, 3, 1'b0, -16'sh8000));
    pending.push_back(mk(lcf_pkg::CMD_FEED, 0, 2, 3, 1'b0, 16'sh0000));
    pending.push_back(mk(lcf_pkg::CMD_FEED, 127, 63, 2, 1'b1, 16'sh1234));
    pending.push_back(mk(lcf_pkg::CMD_W'(int'(lcf_pkg::CMD_FEED) + 1), 127, 63, 3, 1'b1,
                         -16'sh1));
    pending.push_back(mk(lcf_pkg::CMD_W'(int'(lcf_pkg::CMD_FEED) + 2), 0, 0, 0, 1'b0,
                         16'sh7fff));
    pending.push_back(mk(lcf_pkg::CMD_W'(int'(lcf_pkg::CMD_FEED) + 3), 85, 42, 1, 1'b1,
                         -16'sh8000));
    pending.push_back(mk(lcf_pkg::CMD_W_HH, 5, 63, 0, 1'b0, 16'sh7fff));
    pending.push_back(mk(lcf_pkg::CMD_W_IH, 127, 63, 0, 1'b0, 16'sh0100));
    pending.push_back(mk(lcf_pkg::CMD_W_IH, 0, 2, 0, 1'b0, -16'sh8000));
    pending.push_back(mk(lcf_pkg::CMD_W_HH, 3, 1, 0, 1'b0, 16'sh7fff));
    pending.push_back(mk(lcf_pkg::CMD_B_IH, 1, 0, 0, 1'b0, 16'sh7fff));
    pending.push_back(mk(lcf_pkg::CMD_B_HH, 127, 63, 3, 1'b1, -16'sh8000));
    pending.push_back(mk(lcf_pkg::CMD_FEED, 0, 0, 1, 1'b1, 16'sh0800));
    pending.push_back(mk(lcf_pkg::CMD_FEED, 0, 1, 1, 1'b0, -16'sh0800));
    pending.push_back(mk(lcf_pkg::CMD_FEED, 0, 2, 1, 1'b1, 16'sh1000));
    pending.push_back(mk(lcf_pkg::CMD_FEED, 0, 2, 1, 1'b0, 16'sh1000));
    wait_idle();

    // random phases
    for (int p = 0; p < 9; p++) begin
      write_reg(lcf_pkg::REG_INPUT_SIZE, lcf_pkg::CFG_DATA_W'(in_cfg[p]));
      write_reg(lcf_pkg::REG_HIDDEN_SIZE, lcf_pkg::CFG_DATA_W'(hid_cfg[p]));
      ni = eff_in();
      quota = 16;
      no_idle = (p == 3) || (p == 6);
      if (p == 7) hold_tok++;
      cnt = 0;
      while (cnt < quota) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            push_sequence(ni, $urandom_range(0, 3) == 0);
            cnt += ni;
          end
          6, 7: begin
            pending.push_back(mk(lcf_pkg::CMD_W'(int'(lcf_pkg::CMD_W_IH) +
                                                 $urandom_range(0, 3)),
                                 $urandom_range(0, 127), $urandom_range(0, 63),
                                 $urandom_range(0, 3), rand_bit(), rand_val()));
            cnt++;
          end
          8: pending.push_back(mk(lcf_pkg::CMD_W'(int'(lcf_pkg::CMD_FEED) +
                                                  $urandom_range(1, 3)),
                                  $urandom_range(0, 127), $urandom_range(0, 63),
                                  $urandom_range(0, 3), rand_bit(), rand_val()));
          default: begin
            if (ni < IN_MAX)
              pending.push_back(mk(lcf_pkg::CMD_FEED, $urandom_range(0, 127),
                                   $urandom_range(ni, IN_MAX - 1), $urandom_range(0, 3),
                                   rand_bit(), rand_val()));
            else
              push_sequence($urandom_range(1, ni - 1), 1'b1);
          end
        endcase
      end
      wait_idle();
    end

    repeat (200) @(negedge clk_i);
    if (expected_h.size() != 0) errors++;
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
